// ----- sv/ldq_pkg.sv -----
// Shared types and constants for the linear-array deque.
// No dependencies; imported by every module of the block but ldq_ram.
`default_nettype none

package ldq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int FUNC_W    = 2;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 2;
	localparam int IN_W      = 40;  // func + value, padded to bytes
	localparam int OUT_W     = 40;  // status + removed_value, padded to bytes

	localparam logic [FUNC_W-1:0] FN_INS_RIGHT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INS_LEFT  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DEL_LEFT  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_RIGHT = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE         = 2'd0;
	localparam logic [STAT_W-1:0] ST_RIGHT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_LEFT_BLOCKED = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY        = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // latch the input beat
		logic exec;    // run the request against the indices and RAM
		logic load;    // move the result into the output register
	} ldq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} ldq_sts_t;

endpackage

`default_nettype wire

// ----- sv/linear_array_deque_core.sv -----
// Linear-array double-ended queue: top level with stream ports.
// Depends on ldq_pkg, ldq_ctrl, ldq_dp and ldq_ram.
//
// Usage:
//   Slave side (s_*) takes one request per beat: func selects insert right,
//   insert left, delete left or delete right; value is the element to insert.
//   Master side (m_*) gives exactly one result beat per request: status
//   (done, right end full, left end blocked, queue empty) and the removed
//   element for a successful delete, zero otherwise.
//   The elements live in a DEPTH-entry slot RAM that never wraps; a right
//   insert fails at the last slot, a left insert fails at slot 0.
// Sequence:
//   A request goes from accept to result by latching it, executing it against
//   the indices and the RAM port, then loading the output register after the
//   registered RAM read. One request is in flight at a time, so a new request
//   is taken only once the controller is back in idle after the load.
//   s_tready is high only while the controller is idle.
// Reset:
//   arst_n clears the queue to empty and drops m_tvalid. Slot contents are
//   not cleared; only written slots are ever read.
// Backpressure:
//   The result sits in the output register until m_tready. A new request is
//   taken meanwhile; its result waits in the datapath, with the controller
//   held in its load state until the register frees up, and no further
//   request is taken until then.
`default_nettype none

module linear_array_deque_core #(
	parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [ldq_pkg::IN_W-1:0]    s_tdata,   // [1:0] func, [33:2] value, [39:34] zero
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [ldq_pkg::OUT_W-1:0]        m_tdata    // [1:0] status, [33:2] removed_value, [39:34] zero
);
	import ldq_pkg::*;

	ldq_cmd_t          cmd;
	ldq_sts_t          sts;
	logic [STAT_W-1:0] res_status;
	logic [VAL_W-1:0]  res_removed;

	ldq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ldq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_func    (s_tdata[FUNC_W-1:0]),
		.in_value   (s_tdata[FUNC_W +: VAL_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (res_status),
		.out_removed(res_removed)
	);

	assign m_tdata = {{(OUT_W - STAT_W - VAL_W){1'b0}}, res_removed, res_status};

	// an accepted beat always moves the controller into execute
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> cmd.exec)
		else $error("accepted beat not executed");

	// no new beat is taken while a request is being worked on
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !s_tready)
		else $error("input ready during execute");

	// a failed or empty result never carries an element
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_status != ST_DONE) |-> (res_removed == '0))
		else $error("refused request returned data");

endmodule

`default_nettype wire

// ----- sv/ldq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ldq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/ldq_ctrl.sv -----
// Sequencing FSM for the deque: accept, execute, load result.
// Depends on ldq_pkg.
`default_nettype none

module ldq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ldq_pkg::ldq_sts_t sts,
	output ldq_pkg::ldq_cmd_t    cmd
);
	import ldq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && in_valid;
	assign cmd.exec   = (state_q == S_EXEC);
	assign cmd.load   = (state_q == S_LOAD) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// hold until the output register frees up
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/ldq_dp.sv -----
// Deque datapath: indices, empty flag, slot RAM and output register.
// Depends on ldq_pkg and ldq_ram.
`default_nettype none

module ldq_dp #(
	parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ldq_pkg::ldq_cmd_t           cmd,
	output ldq_pkg::ldq_sts_t                sts,
	input  wire logic [ldq_pkg::FUNC_W-1:0]  in_func,
	input  wire logic [ldq_pkg::VAL_W-1:0]   in_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ldq_pkg::STAT_W-1:0]       out_status,
	output logic [ldq_pkg::VAL_W-1:0]        out_removed
);
	import ldq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [FUNC_W-1:0] func_q;
	logic [VAL_W-1:0]  value_q;
	logic [AW-1:0]     head_q, tail_q;
	logic              empty_q;
	logic [STAT_W-1:0] status_q;
	logic              hit_q;     // delete succeeded, RAM data is the result
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_removed_q;

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic [AW-1:0]     head_d, tail_d;
	logic              empty_d;
	logic [STAT_W-1:0] status_d;

	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = '0;
		rd_addr  = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status_d = ST_DONE;
		unique case (func_q) inside
			FN_INS_RIGHT, FN_INS_LEFT: begin
				if (empty_q) begin
					// first element always lands in slot 0
					wr_en   = 1'b1;
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
				end else if (func_q == FN_INS_RIGHT) begin
					if (tail_q == LAST) begin
						status_d = ST_RIGHT_FULL;
					end else begin
						wr_en   = 1'b1;
						tail_d  = tail_q + AW'(1);
						wr_addr = tail_d;
					end
				end else begin
					if (head_q == '0) begin
						status_d = ST_LEFT_BLOCKED;
					end else begin
						wr_en   = 1'b1;
						head_d  = head_q - AW'(1);
						wr_addr = head_d;
					end
				end
			end
			FN_DEL_LEFT, FN_DEL_RIGHT: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = (func_q == FN_DEL_LEFT) ? head_q : tail_q;
					if (head_q == tail_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else if (func_q == FN_DEL_LEFT) begin
						head_d = head_q + AW'(1);
					end else begin
						tail_d = tail_q - AW'(1);
					end
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	ldq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (cmd.exec && wr_en),
		.wr_addr(wr_addr),
		.wr_data(value_q),
		.rd_en  (cmd.exec && rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= in_func;
			value_q <= in_value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			hit_q    <= rd_en;
		end
		if (cmd.load) begin
			out_status_q  <= status_q;
			out_removed_q <= hit_q ? rd_data : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_removed = out_removed_q;

endmodule

`default_nettype wire
